/* hw/rtl/meti_pkg.sv */
// Shared types, constants and fixed-point helpers for the escape-time iterator.
package meti_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 26;
    localparam int CNT_WIDTH   = 16;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ITER   = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_GOING = 1'b1;

    localparam logic [CNT_WIDTH-1:0] MAX_ITER_RESET = 16'd256;

    localparam logic signed [COORD_WIDTH-1:0] WORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] WORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] UWORD_MAX = {COORD_WIDTH{1'b1}};

    // escape thresholds 4.0 and 16.0 in the norm format
    localparam logic [PROD_WIDTH-1:0] NORM_LIM4  = PROD_WIDTH'(4)  << FRAC_BITS;
    localparam logic [PROD_WIDTH-1:0] NORM_LIM16 = PROD_WIDTH'(16) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c_re;
        logic signed [COORD_WIDTH-1:0] c_im;
    } in_beat_t;

    typedef struct packed {
        logic [CNT_WIDTH-1:0]          iter_count;
        logic                          inside_set;
        logic signed [COORD_WIDTH-1:0] escape_z_re;
        logic signed [COORD_WIDTH-1:0] escape_z_im;
        logic [COORD_WIDTH-1:0]        escape_norm;
        logic signed [COORD_WIDTH-1:0] final_z_re;
        logic signed [COORD_WIDTH-1:0] final_z_im;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_EVAL,
        ST_UPDATE,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_RR,
        OP_MUL_II,
        OP_MUL_RI,
        OP_EVAL,
        OP_UPDATE
    } dp_op_t;

    typedef struct packed {
        logic more;  // pass index below the bound
        logic stop;  // escaped, past the stop threshold, keep-going clear
    } dp_status_t;

    // floor-shift a full product and saturate to a signed word
    function automatic logic signed [COORD_WIDTH-1:0] prod_to_word(
        input logic signed [PROD_WIDTH-1:0] p,
        input int unsigned                  sh
    );
        logic signed [PROD_WIDTH-1:0]  s;
        logic signed [COORD_WIDTH-1:0] r;
        s = p >>> sh;
        if (s[PROD_WIDTH-1:COORD_WIDTH-1] == {(PROD_WIDTH-COORD_WIDTH+1){s[PROD_WIDTH-1]}})
            r = s[COORD_WIDTH-1:0];
        else
            r = s[PROD_WIDTH-1] ? WORD_MIN : WORD_MAX;
        return r;
    endfunction

    // non-negative square to unsigned word, saturated
    function automatic logic [COORD_WIDTH-1:0] square_to_uword(
        input logic signed [PROD_WIDTH-1:0] p
    );
        logic [PROD_WIDTH-1:0]  s;
        logic [COORD_WIDTH-1:0] r;
        s = p >> FRAC_BITS;
        if (|s[PROD_WIDTH-1:COORD_WIDTH])
            r = UWORD_MAX;
        else
            r = s[COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] add_sat(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0]   s;
        logic signed [COORD_WIDTH-1:0] r;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            r = s[COORD_WIDTH] ? WORD_MIN : WORD_MAX;
        else
            r = s[COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sub_sat(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0]   s;
        logic signed [COORD_WIDTH-1:0] r;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            r = s[COORD_WIDTH] ? WORD_MIN : WORD_MAX;
        else
            r = s[COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] norm_add(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic [COORD_WIDTH:0]   s;
        logic [COORD_WIDTH-1:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = s[COORD_WIDTH] ? UWORD_MAX : s[COORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/meti_datapath.sv */
// Orbit datapath: shared multiplier, saturating adders, escape bookkeeping.
module meti_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  meti_pkg::dp_op_t                       op,
    input  meti_pkg::in_beat_t                     in_data,
    input  logic [meti_pkg::CNT_WIDTH-1:0]         max_iterations,
    input  logic                                   keep_going_after_escape,
    output meti_pkg::dp_status_t                   status,
    output meti_pkg::out_beat_t                    result
);

    localparam int W = meti_pkg::COORD_WIDTH;
    localparam int P = meti_pkg::PROD_WIDTH;
    localparam int C = meti_pkg::CNT_WIDTH;

    logic signed [W-1:0] c_re_reg, c_im_reg;
    logic signed [W-1:0] orbit_re_reg, orbit_im_reg;
    logic signed [W-1:0] prior_re_reg, prior_im_reg;
    logic signed [W-1:0] esc_re_reg, esc_im_reg;
    logic [W-1:0]        esc_norm_reg;
    logic [C-1:0]        step_reg, count_reg;
    logic                escaped_reg;
    logic signed [P-1:0] prod_reg;
    logic signed [W-1:0] sq_re_reg, diff_reg, acc_re_reg, acc_im_reg;
    logic [W-1:0]        usq_re_reg, usq_im_reg;

    logic signed [W-1:0] mul_a, mul_b;
    logic signed [P-1:0] prod_next;
    logic [W-1:0]        norm;
    logic                esc_now, escaped_next;

    always_comb
    begin
        case (op)
            meti_pkg::OP_MUL_II:
            begin
                mul_a = orbit_im_reg;
                mul_b = orbit_im_reg;
            end
            meti_pkg::OP_MUL_RI:
            begin
                mul_a = orbit_re_reg;
                mul_b = orbit_im_reg;
            end
            default:
            begin
                mul_a = orbit_re_reg;
                mul_b = orbit_re_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // escape test on the norm of the current z
    assign norm         = meti_pkg::norm_add(usq_re_reg, usq_im_reg);
    assign esc_now      = (step_reg != '0) && !escaped_reg
                          && (P'(norm) > meti_pkg::NORM_LIM4);
    assign escaped_next = escaped_reg | esc_now;

    assign status.more = step_reg < max_iterations;
    assign status.stop = escaped_next && (P'(norm) > meti_pkg::NORM_LIM16)
                         && !keep_going_after_escape;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            escaped_reg <= 1'b0;
        end
        else
        begin
            if (op == meti_pkg::OP_LOAD)
            begin
                step_reg    <= '0;
                escaped_reg <= 1'b0;
            end
            else if (op == meti_pkg::OP_EVAL)
            begin
                escaped_reg <= escaped_next;
            end
            else if (op == meti_pkg::OP_UPDATE)
            begin
                step_reg <= step_reg + C'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            meti_pkg::OP_LOAD:
            begin
                c_re_reg     <= in_data.c_re;
                c_im_reg     <= in_data.c_im;
                orbit_re_reg <= in_data.c_re;
                orbit_im_reg <= in_data.c_im;
                prior_re_reg <= in_data.c_re;
                prior_im_reg <= in_data.c_im;
                count_reg    <= '0;
                esc_re_reg   <= '0;
                esc_im_reg   <= '0;
                esc_norm_reg <= '0;
            end
            meti_pkg::OP_MUL_RR:
            begin
                prod_reg <= prod_next;
            end
            meti_pkg::OP_MUL_II:
            begin
                prod_reg   <= prod_next;
                sq_re_reg  <= meti_pkg::prod_to_word(prod_reg, meti_pkg::FRAC_BITS);
                usq_re_reg <= meti_pkg::square_to_uword(prod_reg);
            end
            meti_pkg::OP_MUL_RI:
            begin
                prod_reg   <= prod_next;
                usq_im_reg <= meti_pkg::square_to_uword(prod_reg);
                diff_reg   <= meti_pkg::sub_sat(sq_re_reg,
                                  meti_pkg::prod_to_word(prod_reg, meti_pkg::FRAC_BITS));
            end
            meti_pkg::OP_EVAL:
            begin
                if (esc_now)
                begin
                    count_reg    <= step_reg;
                    esc_re_reg   <= orbit_re_reg;
                    esc_im_reg   <= orbit_im_reg;
                    esc_norm_reg <= norm;
                end
                acc_re_reg <= meti_pkg::add_sat(diff_reg, c_re_reg);
                // cross term 2*re*im: one fraction bit less of shift
                acc_im_reg <= meti_pkg::add_sat(
                                  meti_pkg::prod_to_word(prod_reg, meti_pkg::FRAC_BITS - 1),
                                  c_im_reg);
            end
            meti_pkg::OP_UPDATE:
            begin
                orbit_re_reg <= meti_pkg::add_sat(acc_re_reg, prior_re_reg);
                orbit_im_reg <= meti_pkg::add_sat(acc_im_reg, prior_im_reg);
                prior_re_reg <= orbit_re_reg;
                prior_im_reg <= orbit_im_reg;
                if (!escaped_reg)
                    count_reg <= step_reg + C'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign result.iter_count  = count_reg;
    assign result.inside_set  = !escaped_reg;
    assign result.escape_z_re = esc_re_reg;
    assign result.escape_z_im = esc_im_reg;
    assign result.escape_norm = esc_norm_reg;
    assign result.final_z_re  = orbit_re_reg;
    assign result.final_z_im  = orbit_im_reg;

endmodule

/* hw/rtl/meti_ctrl.sv */
// Pass sequencer: steps the datapath through multiply, evaluate and update.
module meti_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 out_load,
    input  meti_pkg::dp_status_t status,
    output meti_pkg::dp_op_t     op
);

    meti_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= meti_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        op         = meti_pkg::OP_NONE;
        unique case (state_reg)
            meti_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = meti_pkg::OP_LOAD;
                    state_next = meti_pkg::ST_CHECK;
                end
            end
            meti_pkg::ST_CHECK:
            begin
                state_next = status.more ? meti_pkg::ST_MUL_RR : meti_pkg::ST_FINISH;
            end
            meti_pkg::ST_MUL_RR:
            begin
                op         = meti_pkg::OP_MUL_RR;
                state_next = meti_pkg::ST_MUL_II;
            end
            meti_pkg::ST_MUL_II:
            begin
                op         = meti_pkg::OP_MUL_II;
                state_next = meti_pkg::ST_MUL_RI;
            end
            meti_pkg::ST_MUL_RI:
            begin
                op         = meti_pkg::OP_MUL_RI;
                state_next = meti_pkg::ST_EVAL;
            end
            meti_pkg::ST_EVAL:
            begin
                op         = meti_pkg::OP_EVAL;
                state_next = status.stop ? meti_pkg::ST_FINISH : meti_pkg::ST_UPDATE;
            end
            meti_pkg::ST_UPDATE:
            begin
                op         = meti_pkg::OP_UPDATE;
                state_next = meti_pkg::ST_CHECK;
            end
            meti_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = meti_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = meti_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == meti_pkg::ST_CHECK))
        else $error("accepted beat did not start a pass check");

    a_update_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == meti_pkg::ST_UPDATE) |-> ($past(state_reg) == meti_pkg::ST_EVAL))
        else $error("orbit update without a preceding evaluation");

    a_pass_starts_at_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == meti_pkg::ST_MUL_RR) |-> ($past(state_reg) == meti_pkg::ST_CHECK))
        else $error("pass started without a bound check");

    a_finish_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == meti_pkg::ST_FINISH && $past(state_reg) != meti_pkg::ST_FINISH)
        |-> ($past(state_reg) == meti_pkg::ST_CHECK || $past(state_reg) == meti_pkg::ST_EVAL))
        else $error("finish entered from an unexpected state");
`endif

endmodule

/* hw/rtl/manowar_escape_time_iterator.sv */
// Top level of the escape-time iterator: config registers, output register, core.
//
// One pixel coordinate c (signed Q6.26 real and imaginary parts) is taken per
// input beat and produces one result beat. Pixels are processed one at a time.
// A pass of the orbit loop is a bound check, three products (re*re, im*im,
// re*im) through one shared 32x32 multiplier, an evaluation step (norm,
// escape test, first saturating add) and an update step (second saturating
// add). The output register lets a new pixel be accepted while the previous
// result beat is still waiting downstream. max_iterations of 0 yields the
// coordinate itself as final z with a count of 0. Configuration (index 0:
// max_iterations, index 1: keep_going_after_escape) is written through
// cfg_we/cfg_index/cfg_data and should only change while the block is idle.
module manowar_escape_time_iterator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  meti_pkg::in_beat_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output meti_pkg::out_beat_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [meti_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [meti_pkg::CFG_WIDTH-1:0]       cfg_data
);

    logic [meti_pkg::CNT_WIDTH-1:0] max_iter_reg;
    logic                           keep_going_reg;

    logic                 out_valid_reg;
    meti_pkg::out_beat_t  out_data_reg;

    meti_pkg::dp_op_t     op;
    meti_pkg::dp_status_t status;
    meti_pkg::out_beat_t  result;
    logic                 out_free;
    logic                 out_load;

    // config registers, to be written only between pixels; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= meti_pkg::MAX_ITER_RESET;
            keep_going_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                meti_pkg::CFG_MAX_ITER:   max_iter_reg   <= cfg_data;
                meti_pkg::CFG_KEEP_GOING: keep_going_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // result slot is free if empty or drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    meti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .op       (op)
    );

    meti_datapath u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .op                      (op),
        .in_data                 (in_data),
        .max_iterations          (max_iter_reg),
        .keep_going_after_escape (keep_going_reg),
        .status                  (status),
        .result                  (result)
    );

endmodule

/* tb/meti_escape_checker.sv */
// Result checker for the escape-time iterator: predicts every pixel result and compares beats.
module meti_escape_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  meti_pkg::in_beat_t                 in_data,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  meti_pkg::out_beat_t                out_data,
    input  logic                               cfg_we,
    input  logic [meti_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [meti_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                               run_done,
    output int                                 pending,
    output int                                 fail_count
);

    localparam int     FB     = meti_pkg::FRAC_BITS;
    localparam longint S_HI   = 64'sd2147483647;
    localparam longint S_LO   = -64'sd2147483648;
    localparam longint U_HI   = 64'sd4294967295;
    localparam longint NORM4  = longint'(4) << FB;
    localparam longint NORM16 = longint'(16) << FB;

    logic [15:0] bound_cfg = meti_pkg::MAX_ITER_RESET;
    logic        keep_cfg  = 1'b0;

    meti_pkg::out_beat_t pending_escapes[$];
    meti_pkg::out_beat_t want;
    int        queued       = 0;
    int        mismatch_cnt = 0;
    int        beat_no      = 0;

    assign pending    = queued;
    assign fail_count = mismatch_cnt + (run_done ? queued : 0);

    function automatic logic signed [31:0] clamp_signed(input longint v);
        longint c;
        c = v;
        if (c > S_HI)
            c = S_HI;
        else if (c < S_LO)
            c = S_LO;
        return c[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        return clamp_signed(longint'(a) + longint'(b));
    endfunction

    // exact 64-bit product, floored shift, then clamp
    function automatic logic signed [31:0] shifted_product(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input int                 sh
    );
        longint p;
        p = longint'(a) * longint'(b);
        return clamp_signed(p >>> sh);
    endfunction

    function automatic meti_pkg::out_beat_t predict_escape(input meti_pkg::in_beat_t px);
        meti_pkg::out_beat_t r;
        logic signed [31:0] zr, zi, prev_re, prev_im, sq_r, sq_i, xr, nr, ni;
        longint             sr, si, nrm;
        logic               escaped, halted;
        int unsigned        k;
        r       = '0;
        zr      = px.c_re;
        zi      = px.c_im;
        prev_re = zr;
        prev_im = zi;
        escaped = 1'b0;
        halted  = 1'b0;
        k       = 0;
        while (k < bound_cfg && !halted)
        begin
            sr = (longint'(zr) * longint'(zr)) >>> FB;
            si = (longint'(zi) * longint'(zi)) >>> FB;
            if (sr > U_HI)
                sr = U_HI;
            if (si > U_HI)
                si = U_HI;
            nrm = sr + si;
            if (nrm > U_HI)
                nrm = U_HI;
            if (k > 0 && !escaped && nrm > NORM4)
            begin
                escaped       = 1'b1;
                r.iter_count  = k[15:0];
                r.escape_z_re = zr;
                r.escape_z_im = zi;
                r.escape_norm = nrm[31:0];
            end
            if (escaped && nrm > NORM16 && !keep_cfg)
                halted = 1'b1;
            else
            begin
                sq_r    = shifted_product(zr, zr, FB);
                sq_i    = shifted_product(zi, zi, FB);
                xr      = shifted_product(zr, zi, FB - 1);  // 2*re*im
                ni      = sat_add(sat_add(xr, px.c_im), prev_im);
                nr      = sat_add(sat_add(clamp_signed(longint'(sq_r) - longint'(sq_i)),
                                          px.c_re), prev_re);
                prev_re = zr;
                prev_im = zi;
                zr      = nr;
                zi      = ni;
                if (!escaped)
                    r.iter_count = 16'(k + 1);
                k++;
            end
        end
        r.inside_set = !escaped;
        r.final_z_re = zr;
        r.final_z_im = zi;
        return r;
    endfunction

    function automatic string beat_text(input meti_pkg::out_beat_t b);
        return $sformatf("cnt=%0d inside=%0b esc=%h,%h norm=%h z=%h,%h", b.iter_count,
                         b.inside_set, b.escape_z_re, b.escape_z_im, b.escape_norm,
                         b.final_z_re, b.final_z_im);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_escapes.delete();
            bound_cfg = meti_pkg::MAX_ITER_RESET;
            keep_cfg  = 1'b0;
            queued    = 0;
        end
        else
        begin
            // retire first: a result beat never belongs to the pixel taken at the same edge
            if (out_valid && out_ready)
            begin
                beat_no++;
                if (pending_escapes.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("beat %0d with no pixel outstanding: %s",
                                 beat_no, beat_text(out_data));
                end
                else
                begin
                    want = pending_escapes.pop_front();
                    if (want.iter_count  !== out_data.iter_count  ||
                        want.inside_set  !== out_data.inside_set  ||
                        want.escape_z_re !== out_data.escape_z_re ||
                        want.escape_z_im !== out_data.escape_z_im ||
                        want.escape_norm !== out_data.escape_norm ||
                        want.final_z_re  !== out_data.final_z_re  ||
                        want.final_z_im  !== out_data.final_z_im)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("beat %0d expected %s", beat_no, beat_text(want));
                            $display("beat %0d actual   %s", beat_no, beat_text(out_data));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                pending_escapes.push_back(predict_escape(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    meti_pkg::CFG_MAX_ITER:   bound_cfg = cfg_data;
                    meti_pkg::CFG_KEEP_GOING: keep_cfg  = cfg_data[0];
                    default:                  ;
                endcase
            end
            queued = pending_escapes.size();
        end
    end

endmodule

/* tb/tb_manowar_escape_time_iterator.sv */
// Testbench top for the escape-time iterator: clock, reset, pixel stimulus and verdict.
module tb_manowar_escape_time_iterator;

    // Random part stops once this many pixels have gone in.
    localparam int RANDOM_PIXELS = 1650;

    // Slowest correct run, roughly: one 65535-pass pixel, a dozen 256-pass
    // pixels, ~1650 random pixels at <= 40 passes plus long gaps and stalls,
    // and a few 20-pixel phases at up to 300 passes. The limit is several
    // times the length of such a run.
    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    // 1.0 in Q6.26
    localparam int Q = 1 << meti_pkg::FRAC_BITS;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    meti_pkg::in_beat_t                   in_data   = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    meti_pkg::out_beat_t                  out_data;
    logic                                 cfg_we    = 1'b0;
    logic [meti_pkg::CFG_IDX_WIDTH-1:0]   cfg_index = meti_pkg::CFG_MAX_ITER;
    logic [meti_pkg::CFG_WIDTH-1:0]       cfg_data  = '0;
    logic                                 run_done  = 1'b0;

    int pending;
    int fail_count;

    // stimulus bookkeeping
    logic            calm       = 1'b0;  // phase with back-to-back pixels
    int unsigned     ready_span = 0;
    int unsigned     sent;
    int unsigned     bound;
    int unsigned     burst;
    int unsigned     pick;
    longint unsigned cycle_cnt  = 0;

    always #5 clk = ~clk;

    manowar_escape_time_iterator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    meti_escape_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .run_done   (run_done),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Watchdog: a hung handshake or a runaway orbit loop ends here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("manowar_escape_time_iterator: mismatch");
            $finish;
        end
    end

    // Downstream backpressure. Ready flips at the end of each span; ready-high
    // spans are sometimes long (no stalls at all), and the odd stall is long
    // so the output register has to hold a beat while the core is mid-pixel.
    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            out_ready <= !out_ready;
            if (!out_ready)
                ready_span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 12);
            else
                ready_span = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                          : $urandom_range(15, 50);
        end
        else
            ready_span = ready_span - 1;
    end

    // Gap before the next pixel: none in calm phases, otherwise mostly short.
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] corner_coord();
        case ($urandom_range(0, 4))
            0:       return meti_pkg::WORD_MIN;
            1:       return meti_pkg::WORD_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Most pixels land around the set where orbits are long; the rest span
    // a wider window, the whole word, or the saturation corners.
    function automatic meti_pkg::in_beat_t random_pixel();
        meti_pkg::in_beat_t px;
        int unsigned        r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            px.c_re = $urandom_range(0, 184549376) - 134217728;  // -2.0 .. 0.75
            px.c_im = $urandom_range(0, 167772160) - 83886080;   // -1.25 .. 1.25
        end
        else if (r < 80)
        begin
            px.c_re = $urandom_range(0, 536870912) - 268435456;  // -4.0 .. 4.0
            px.c_im = $urandom_range(0, 536870912) - 268435456;
        end
        else if (r < 95)
        begin
            px.c_re = $urandom;
            px.c_im = $urandom;
        end
        else
        begin
            px.c_re = corner_coord();
            px.c_im = corner_coord();
        end
        return px;
    endfunction

    // Entered at a falling edge with no pending update of in_valid; returns at
    // the falling edge after the beat went in, so a zero gap keeps valid high.
    task automatic send_pixel(input logic signed [31:0] re, input logic signed [31:0] im);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.c_re <= re;
        in_data.c_im <= im;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [meti_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding pixel to come back, then a
    // short pause so the core is surely back in idle before a register write.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings (256 passes, stop after escape): origin stays inside
        // for the full bound, the four saturation corners, a one-LSB seed,
        // a few points on the axes, and 3.0 which escapes on the same pass
        // where it passes the stop threshold.
        send_pixel(0, 0);
        send_pixel(meti_pkg::WORD_MIN, meti_pkg::WORD_MIN);
        send_pixel(meti_pkg::WORD_MAX, meti_pkg::WORD_MAX);
        send_pixel(meti_pkg::WORD_MIN, meti_pkg::WORD_MAX);
        send_pixel(meti_pkg::WORD_MAX, meti_pkg::WORD_MIN);
        send_pixel(-1, -1);
        send_pixel(Q / 4, 0);
        send_pixel(0, Q);
        send_pixel(-Q, 0);
        send_pixel(2 * Q, 0);
        send_pixel(3 * Q, 0);
        settle();

        // Zero bound: no pass at all, final z is c itself.
        write_reg(meti_pkg::CFG_MAX_ITER, 16'd0);
        send_pixel(3 * Q / 2, -Q / 2);
        send_pixel(meti_pkg::WORD_MIN, meti_pkg::WORD_MAX);
        settle();

        // Single pass, keep going after escape.
        write_reg(meti_pkg::CFG_MAX_ITER, 16'd1);
        write_reg(meti_pkg::CFG_KEEP_GOING, 16'h0001);
        send_pixel(3 * Q, 0);
        send_pixel(meti_pkg::WORD_MAX, meti_pkg::WORD_MAX);
        settle();

        // Largest bound; upper data bits set on the flag write, flag itself clear.
        // The origin runs the full 65535 passes, so the count hits the top.
        write_reg(meti_pkg::CFG_MAX_ITER, 16'hFFFF);
        write_reg(meti_pkg::CFG_KEEP_GOING, 16'hFFFE);
        send_pixel(0, 0);
        send_pixel(2 * Q, 0);
        settle();

        // Keep going after escape: the orbit runs into saturation.
        write_reg(meti_pkg::CFG_MAX_ITER, 16'd40);
        write_reg(meti_pkg::CFG_KEEP_GOING, 16'h0001);
        send_pixel(3 * Q, 0);
        send_pixel(meti_pkg::WORD_MIN, meti_pkg::WORD_MIN);
        send_pixel(-2 * Q, Q / 8);
        settle();

        // Random phases: each picks a bound and a flag, then a burst of pixels.
        // Large bounds get short bursts to keep the run length in check.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                bound = 0;
            else if (pick < 15)
                bound = $urandom_range(1, 3);
            else if (pick < 85)
                bound = $urandom_range(4, 40);
            else
                bound = $urandom_range(41, 300);
            burst = (bound > 40) ? 20 : $urandom_range(60, 160);
            calm  = ($urandom_range(0, 4) == 0);
            write_reg(meti_pkg::CFG_MAX_ITER, 16'(bound));
            write_reg(meti_pkg::CFG_KEEP_GOING, 16'($urandom));
            repeat (burst)
            begin
                meti_pkg::in_beat_t px;
                px = random_pixel();
                send_pixel(px.c_re, px.c_im);
                sent++;
            end
            settle();
        end

        repeat (20) @(negedge clk);
        run_done <= 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("manowar_escape_time_iterator: match");
        else
            $display("manowar_escape_time_iterator: mismatch");
        $finish;
    end

endmodule
